FILE: rtl/nfid_pkg.sv
// shared constants, linear power table and sequencer states of the noise floor detector
`default_nettype none
package nfid_pkg;

  localparam int MAX_SAMPLES_DEF = 16;
  localparam int NF_HIGH = -10;
  localparam int NF_LOW = -120;

  localparam int LIN_W = 50;
  localparam int LIN_N = NF_HIGH - NF_LOW + 1;
  localparam int WIN_W = 16;
  localparam int IVL_W = 12;
  localparam int SUB_W = 16;

  localparam logic [1:0] CFG_WINDOW_TIME = 2'd0;
  localparam logic [1:0] CFG_INTERVAL    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd2;
  localparam logic [1:0] CFG_BACKUP_CH   = 2'd3;

  localparam int unsigned MANT [10] = '{1000, 1259, 1585, 1995, 2512, 3162, 3981, 5012,
                                        6310, 7943};

  typedef logic [LIN_W-1:0] lin_tab_t [LIN_N];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT,
    ST_WRITE,
    ST_WRAP,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_SCAN,
    ST_DONE
  } state_t;

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t t;
    logic [LIN_W-1:0] p;
    int idx;
    p = LIN_W'(1);
    idx = 0;
    for (int q = 0; q < 12; q++) begin
      for (int r = 0; r < 10; r++) begin
        if (idx < LIN_N) t[idx] = LIN_W'(MANT[r]) * p;
        idx++;
      end
      p = p * LIN_W'(10);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  // linear power in 1e-15 mW of a sample clamped to the valid range
  function automatic logic [LIN_W-1:0] lin_of_dbm(logic signed [7:0] d);
    logic [6:0] k;
    if (d < 8'sd0 - 8'sd120) k = 7'd0;
    else if (d > 8'sd0 - 8'sd10) k = 7'(LIN_N - 1);
    else k = 7'(d + 8'sd120);
    return LIN_TAB[k];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/noise_floor_interference_detector.sv
// noise floor interference detector top level with its sequencer
// Input beats carry one signed dBm noise sample in in_tdata. Every accepted beat gives
// exactly one output beat with the taken and window error flags, the averaged noise in
// dBm (0 while the window fills) and a switch request with the backup channel.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle; the block itself does not enforce it.
// One sample is worked by a small sequencer around one shared subtractor:
//   window count by repeated subtraction of the interval from the window time
//   ring write and slot wrap by repeated subtraction of the count
//   when the window is full: ring reads and linear sums,
//   restoring division of the sum by the count and table search back to dBm
// A dropped sample goes from idle straight to the final step.
// in_tready is high only while the sequencer is idle; one finished result may wait in
// the output register while the next beat is accepted, and a stalled receiver holds
// the sequencer in its final step until that register is free.
// Reset clears the configuration to its defaults, the write slot and the fill count;
// ring contents are not cleared and no clearing pass is run.
`default_nettype none
module noise_floor_interference_detector #(
  parameter int MAX_SAMPLES = nfid_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // noise_dbm
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // sample_taken, window_error, avg_noise_dbm[7:0], switch_request, switch_channel[7:0]
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = nfid_pkg::LIN_W + CW;
  localparam int BW = $clog2(SUM_W);
  localparam int SUB_W = nfid_pkg::SUB_W;

  nfid_pkg::state_t state_r, state_nxt;

  logic [15:0] window_r;
  logic [11:0] interval_r;
  logic [7:0]  thr_r;
  logic [7:0]  backup_r;

  logic signed [7:0] nf_r, nf_nxt;
  logic [SUB_W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ws_r, ws_nxt;
  logic [AW:0]       wtmp_r, wtmp_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BW-1:0]     bit_r, bit_nxt;
  logic [6:0]        k_r, k_nxt;

  logic              taken_r, taken_nxt;
  logic              werr_r, werr_nxt;
  logic signed [7:0] avg_r, avg_nxt;
  logic              req_r, req_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r, out_data_nxt;

  logic [SUB_W-1:0] sub_a, sub_b;
  logic [SUB_W:0]   sub_d;
  logic             sub_ge;
  logic [CW:0]      div_sh;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic       in_acc;
  logic       nf_bad;
  logic       disabled;
  logic       hit;
  logic signed [7:0] avg_new;

  nfid_ram #(
    .WIDTH(8),
    .DEPTH(MAX_SAMPLES)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ws_r),
    .wdata(nf_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == nfid_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign nf_bad   = ($signed(in_tdata) > (8'sd0 - 8'sd10)) ||
                    ($signed(in_tdata) < (8'sd0 - 8'sd120));
  assign disabled = (backup_r == 8'd0) || (thr_r == 8'd0) || (window_r == 16'd0);

  assign div_sh = {rem_r, sum_r[SUM_W-1]};

  // shared subtractor
  always_comb begin
    case (state_r)
      nfid_pkg::ST_CNT: begin
        sub_a = acc_r;
        sub_b = SUB_W'(interval_r);
      end
      nfid_pkg::ST_WRAP: begin
        sub_a = SUB_W'(wtmp_r);
        sub_b = SUB_W'(count_r);
      end
      nfid_pkg::ST_DIV: begin
        sub_a = SUB_W'(div_sh);
        sub_b = SUB_W'(count_r);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_d[SUB_W];

  assign hit     = (SUM_W'(nfid_pkg::LIN_TAB[k_r]) >= sum_r) ||
                   (k_r == 7'(nfid_pkg::LIN_N - 1));
  assign avg_new = $signed(8'(k_r) - 8'd120);

  always_comb begin
    state_nxt     = state_r;
    nf_nxt        = nf_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    ws_nxt        = ws_r;
    wtmp_nxt      = wtmp_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    taken_nxt     = taken_r;
    werr_nxt      = werr_r;
    avg_nxt       = avg_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];

    case (state_r)
      nfid_pkg::ST_IDLE: begin
        if (in_acc) begin
          nf_nxt    = $signed(in_tdata);
          taken_nxt = 1'b0;
          werr_nxt  = 1'b0;
          avg_nxt   = '0;
          req_nxt   = 1'b0;
          acc_nxt   = window_r;
          cnt_nxt   = '0;
          if (nf_bad || disabled) begin
            state_nxt = nfid_pkg::ST_DONE;
          end else if (interval_r == 12'd0) begin
            werr_nxt  = 1'b1;
            state_nxt = nfid_pkg::ST_DONE;
          end else begin
            state_nxt = nfid_pkg::ST_CNT;
          end
        end
      end
      nfid_pkg::ST_CNT: begin
        if (cnt_r == CW'(MAX_SAMPLES) || !sub_ge) begin
          count_nxt = cnt_r;
          if (cnt_r == '0) begin
            werr_nxt  = 1'b1;
            state_nxt = nfid_pkg::ST_DONE;
          end else begin
            state_nxt = nfid_pkg::ST_WRITE;
          end
        end else begin
          acc_nxt = sub_d[SUB_W-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      nfid_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        wtmp_nxt  = {1'b0, ws_r} + (AW+1)'(1);
        state_nxt = nfid_pkg::ST_WRAP;
      end
      nfid_pkg::ST_WRAP: begin
        if (sub_ge) begin
          wtmp_nxt = sub_d[AW:0];
        end else begin
          ws_nxt    = wtmp_r[AW-1:0];
          taken_nxt = 1'b1;
          if (fill_r < count_r) begin
            fill_nxt  = fill_r + CW'(1);
            state_nxt = nfid_pkg::ST_DONE;
          end else begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = nfid_pkg::ST_SUM_RD;
          end
        end
      end
      nfid_pkg::ST_SUM_RD: begin
        state_nxt = nfid_pkg::ST_SUM_ACC;
      end
      nfid_pkg::ST_SUM_ACC: begin
        sum_nxt = sum_r + SUM_W'(nfid_pkg::lin_of_dbm($signed(ram_rdata)));
        idx_nxt = idx_r + CW'(1);
        if (idx_r == count_r - CW'(1)) begin
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = nfid_pkg::ST_DIV;
        end else begin
          state_nxt = nfid_pkg::ST_SUM_RD;
        end
      end
      nfid_pkg::ST_DIV: begin
        if (sub_ge) rem_nxt = sub_d[CW-1:0];
        else rem_nxt = div_sh[CW-1:0];
        sum_nxt = {sum_r[SUM_W-2:0], sub_ge};
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(SUM_W - 1)) begin
          k_nxt     = '0;
          state_nxt = nfid_pkg::ST_SCAN;
        end
      end
      nfid_pkg::ST_SCAN: begin
        if (hit) begin
          avg_nxt = avg_new;
          if (avg_new > $signed(thr_r)) begin
            req_nxt  = 1'b1;
            ws_nxt   = '0;
            fill_nxt = '0;
          end
          state_nxt = nfid_pkg::ST_DONE;
        end else begin
          k_nxt = k_r + 7'd1;
        end
      end
      nfid_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, (req_r ? backup_r : 8'd0), req_r, avg_r, werr_r, taken_r};
          state_nxt     = nfid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nfid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfid_pkg::ST_IDLE;
      ws_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      window_r    <= 16'd0;
      interval_r  <= 12'd15;
      thr_r       <= 8'd0;
      backup_r    <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          nfid_pkg::CFG_WINDOW_TIME: window_r   <= cfg_data;
          nfid_pkg::CFG_INTERVAL:    interval_r <= cfg_data[11:0];
          nfid_pkg::CFG_THRESHOLD:   thr_r      <= cfg_data[7:0];
          nfid_pkg::CFG_BACKUP_CH:   backup_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    nf_r       <= nf_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    count_r    <= count_nxt;
    wtmp_r     <= wtmp_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    k_r        <= k_nxt;
    taken_r    <= taken_nxt;
    werr_r     <= werr_nxt;
    avg_r      <= avg_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_SAMPLES))
    else $error("fill count beyond ring depth");

  a_req_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[10] |-> out_data_r[0])
    else $error("switch request without a stored sample");

  a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1] |-> !out_data_r[0] && out_data_r[10:2] == 9'd0)
    else $error("window error beat carries data");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != nfid_pkg::ST_IDLE)
    else $error("sequencer idle after accepted beat");

endmodule
`default_nettype wire

FILE: rtl/nfid_ram.sv
// generic single write port ram with registered read
`default_nettype none
module nfid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: dv/noise_floor_interference_detector_tb.sv
// self-checking testbench of the noise floor interference detector
`default_nettype none
module noise_floor_interference_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BEATS = 1250;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int RING_DEPTH = 16;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [15:0] value;
    logic        typed;
    logic [23:0] result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;   // noise_dbm
  logic out_tvalid;
  logic out_tready = 1'b0;
  // sample_taken, window_error, avg_noise_dbm[7:0], switch_request, switch_channel[7:0]
  logic [23:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  noise_floor_interference_detector uut (.*);

  always #4 clk = ~clk;

  // mirror of the detector state
  logic [15:0] win_time = 16'd0;
  logic [11:0] interval = 12'd15;
  logic signed [7:0] thresh = 8'sd0;
  logic [7:0] backup_ch = 8'd0;
  logic signed [7:0] ring [RING_DEPTH];
  int unsigned wr_slot = 0;
  int unsigned fill = 0;

  logic [23:0] pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int switches_seen = 0;
  int beats_sent = 0;
  longint cycles = 0;
  bit quiet = 1'b0;

  function automatic longint unsigned power_of_dbm(int d);
    longint unsigned m [10] = '{1000, 1259, 1585, 1995, 2512, 3162, 3981, 5012, 6310, 7943};
    longint unsigned v;
    int k;
    if (d < nfid_pkg::NF_LOW) d = nfid_pkg::NF_LOW;
    if (d > nfid_pkg::NF_HIGH) d = nfid_pkg::NF_HIGH;
    k = d - nfid_pkg::NF_LOW;
    v = m[k % 10];
    for (int i = 0; i < k / 10; i++) v = v * 10;
    return v;
  endfunction

  function automatic int dbm_of_power(longint unsigned a);
    for (int d = nfid_pkg::NF_LOW; d < nfid_pkg::NF_HIGH; d++)
      if (power_of_dbm(d) >= a) return d;
    return nfid_pkg::NF_HIGH;
  endfunction

  function automatic logic [23:0] detect(logic signed [7:0] nf);
    int unsigned cnt;
    longint unsigned sum;
    int avg;
    logic req;
    if (nf > nfid_pkg::NF_HIGH || nf < nfid_pkg::NF_LOW) return 24'h0;
    if (backup_ch == 0 || thresh == 0 || win_time == 0) return 24'h0;
    cnt = (interval == 0) ? 0 : win_time / interval;
    if (cnt > RING_DEPTH) cnt = RING_DEPTH;
    if (cnt == 0) return 24'h2;
    ring[wr_slot % RING_DEPTH] = nf;
    wr_slot = (wr_slot + 1) % cnt;
    if (fill < cnt) begin
      fill++;
      return 24'h1;
    end
    sum = 0;
    for (int i = 0; i < cnt; i++) sum += power_of_dbm(ring[i]);
    avg = dbm_of_power(sum / cnt);
    req = avg > thresh;
    if (req) begin
      wr_slot = 0;
      fill = 0;
    end
    return {5'd0, req ? backup_ch : 8'd0, req, 8'(avg), 1'b0, 1'b1};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(logic [7:0] nf, logic typed, logic [23:0] result);
    logic [23:0] predicted;
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= nf;
    do @(posedge clk); while (!in_tready);
    predicted = detect(nf);
    pending_results.push_back(typed ? result : predicted);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // sender holds off until every result has drained
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      nfid_pkg::CFG_WINDOW_TIME: win_time = val;
      nfid_pkg::CFG_INTERVAL:    interval = val[11:0];
      nfid_pkg::CFG_THRESHOLD:   thresh = val[7:0];
      default:                   backup_ch = val[7:0];
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_setup();
    int n;
    logic [15:0] wt;
    logic [11:0] iv;
    n = $urandom_range(0, 9);
    iv = (n == 0) ? 12'd1 : (n == 1) ? 12'd4095 : (n == 2) ? 12'd0 :
         12'($urandom_range(1, 3600));
    n = $urandom_range(0, 19);
    if (n == 0) wt = 16'd0;
    else if (n == 1) wt = 16'hFFFF;
    else if (n < 4) wt = 16'($urandom_range(0, 65535));
    else wt = 16'(((iv == 0 ? 1 : iv) * $urandom_range(1, 17) +
                   $urandom_range(0, iv == 0 ? 0 : iv - 1)) & 32'hFFFF);
    drain();
    write_reg(nfid_pkg::CFG_INTERVAL, 16'(iv));
    write_reg(nfid_pkg::CFG_WINDOW_TIME, wt);
    n = $urandom_range(0, 19);
    write_reg(nfid_pkg::CFG_THRESHOLD,
              (n == 0) ? 16'h0 : (n == 1) ? 16'h0088 : (n == 2) ? 16'h00FF :
              16'(8'($signed($urandom_range(0, 110)) - 120)));
    n = $urandom_range(0, 19);
    write_reg(nfid_pkg::CFG_BACKUP_CH, (n == 0) ? 16'h0 : (n == 1) ? 16'h00FF :
              16'($urandom_range(1, 255)));
    end_writes();
  endtask

  function automatic logic [7:0] random_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'($urandom_range(0, 255));
    if (r < 40) return 8'($signed($urandom_range(0, 30)) - 40);
    return 8'($signed($urandom_range(0, 110)) - 120);
  endfunction

  stim_row_t dir_tab [] = '{
    '{ROW_BEAT, 2'd0, 16'h0080, 1'b1, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h007F, 1'b1, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F6, 1'b1, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h0088, 1'b1, 24'h0},
    '{ROW_CFG, nfid_pkg::CFG_WINDOW_TIME, 16'd240, 1'b0, 24'h0},
    '{ROW_CFG, nfid_pkg::CFG_THRESHOLD, 16'h00C4, 1'b0, 24'h0},
    '{ROW_CFG, nfid_pkg::CFG_BACKUP_CH, 16'd7, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h0088, 1'b1, 24'h1},
    '{ROW_BEAT, 2'd0, 16'h00F6, 1'b1, 24'h1},
    '{ROW_BEAT, 2'd0, 16'h0087, 1'b1, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F7, 1'b1, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00A0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00B0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00C0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00D0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00E0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00A8, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00B8, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00C8, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00D8, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00E8, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h0090, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h0098, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F4, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F2, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F6, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00F6, 1'b0, 24'h0},
    '{ROW_CFG, nfid_pkg::CFG_INTERVAL, 16'd0, 1'b0, 24'h0},
    '{ROW_BEAT, 2'd0, 16'h00CE, 1'b1, 24'h2}
  };

  always @(negedge clk) begin
    if (quiet) out_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 90) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[10]) switches_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        logic [23:0] want;
        want = pending_results.pop_front();
        if (want !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: taken %b/%b err %b/%b avg %0d/%0d req %b/%b ch %0d/%0d",
                     results_seen, want[0], out_tdata[0], want[1], out_tdata[1],
                     $signed(want[9:2]), $signed(out_tdata[9:2]), want[10], out_tdata[10],
                     want[18:11], out_tdata[18:11]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("noise_floor_interference_detector regression: fail");
      $finish;
    end
  end

  initial begin
    int sent;
    int phase_len;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_CFG) drain();
        write_reg(dir_tab[i].index, dir_tab[i].value);
        if (dir_tab[i+1].kind != ROW_CFG) end_writes();
      end else begin
        send_beat(dir_tab[i].value[7:0], dir_tab[i].typed, dir_tab[i].result);
      end
    end
    sent = 0;
    while (sent < RAND_BEATS) begin
      random_setup();
      quiet = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(30, 90);
      repeat (phase_len) begin
        send_beat(random_noise(), 1'b0, 24'h0);
        sent++;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d sample beats over random window, interval, threshold and channel settings,",
             beats_sent);
    $display("%0d results checked, %0d switch requests, %0d mismatches",
             results_seen, switches_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("noise_floor_interference_detector regression: pass");
    else
      $display("noise_floor_interference_detector regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
